@@ hdl/xorshift1024_star_rng_core_defines.svh @@
// Assertion macros for the xorshift1024* generator core.
// Used by the top level; expects i_clk and i_rst_n in the including scope.
`ifndef XORSHIFT1024_STAR_RNG_CORE_DEFINES_SVH
`define XORSHIFT1024_STAR_RNG_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define XS1024_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define XS1024_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/xs1024_pkg.sv @@
// Shared types and constants for the xorshift1024* generator core.
// No dependencies; imported by the top level of the core and by the test files.
`default_nettype none

package xs1024_pkg;

    localparam logic [34:0] SEED_STEP = 35'd1812433253;
    localparam logic [63:0] DRAW_MULT = 64'd1181783497276652981;
    localparam int unsigned MIX_SHL   = 31;
    localparam int unsigned MIX_SHR   = 11;
    localparam int unsigned SEED_SHR  = 30;

    typedef enum logic [2:0] {
        REQ_DRAW       = 3'd0,
        REQ_RANGED     = 3'd1,
        REQ_NEW_SEED   = 3'd2,
        REQ_RESET_SEED = 3'd3,
        REQ_INIT       = 3'd4
    } t_req_code;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [63:0] seed_value;
        logic [31:0] range_low;
        logic [31:0] range_high;
        logic        signed_bounds;
    } t_req;

    typedef struct packed {
        logic        accepted;
        logic [63:0] raw_value;
        logic [31:0] ranged_value;
    } t_result;

endpackage

`default_nettype wire

@@ hdl/xorshift1024_star_rng_core.sv @@
// Top level of the xorshift1024* generator: word store, sequencer, shared multiplier.
// Depends on xs1024_pkg, xs1024_divu and xorshift1024_star_rng_core_defines.svh.
`default_nettype none

// A request is taken when i_start is high and o_busy is low; its result word is
// on o_result while o_done is high for exactly one cycle, and cannot be held off.
// A plain draw goes through one store read, one step of mixing and write-back, and
// four steps on the single 32x32 multiplier that forms the 64-bit product from
// three partial products, then raises o_done. A ranged draw then runs the
// one-bit-per-cycle remainder unit unless the span is full. Seeding writes the
// sixteen store words one per cycle. Refused or unknown requests answer on the
// cycle after accept.

`include "xorshift1024_star_rng_core_defines.svh"

module xorshift1024_star_rng_core
    import xs1024_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_req    i_req,
    output logic         o_busy,
    output logic         o_done,
    output t_result      o_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MIX,
        S_MUL,
        S_DIV,
        S_FILL
    } t_state;

    t_state      r_state;
    logic [3:0]  r_ptr;
    logic [63:0] r_first_seed;
    logic [63:0] r_active_seed;
    logic        r_seeded;
    logic [15:0] r_valid;
    logic        r_ranged;
    logic [31:0] r_lo;
    logic [31:0] r_span;
    logic [1:0]  r_step;
    logic [63:0] r_t;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [3:0]  r_fidx;
    logic [34:0] r_off;
    logic [63:0] r_base;
    logic        r_div_start;
    logic        r_done;
    t_result     r_result;

    logic [63:0] mem_words [16];
    logic [63:0] r_rd_s;
    logic [63:0] r_rd_t;
    logic        r_vs;
    logic        r_vt;

    logic [3:0]  w_ptr_nx;
    logic        w_accept;
    logic        w_rev;
    logic [31:0] w_lo;
    logic [31:0] w_hi;
    logic [63:0] w_s;
    logic [63:0] w_t0;
    logic [63:0] w_t1;
    logic [63:0] w_t2;
    logic [63:0] w_t3;
    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [63:0] w_mul;
    logic [63:0] n_acc;
    logic        w_we;
    logic [3:0]  w_waddr;
    logic [63:0] w_wdata;
    logic        w_div_done;
    logic [31:0] w_div_rem;

    assign w_ptr_nx = r_ptr + 4'd1;
    assign w_accept = i_start && (r_state == S_IDLE);

    assign w_rev = i_req.signed_bounds ?
                   ($signed(i_req.range_high) < $signed(i_req.range_low)) :
                   (i_req.range_high < i_req.range_low);
    assign w_lo  = w_rev ? i_req.range_high : i_req.range_low;
    assign w_hi  = w_rev ? i_req.range_low  : i_req.range_high;

    assign w_s  = r_vs ? r_rd_s : '0;
    assign w_t0 = r_vt ? r_rd_t : '0;
    assign w_t1 = w_t0 ^ (w_t0 << MIX_SHL);
    assign w_t2 = w_t1 ^ (w_t1 >> MIX_SHR);
    assign w_t3 = w_t2 ^ w_s ^ (w_s >> SEED_SHR);

    always_comb begin
        case (r_step)
            2'd0: begin
                w_ma = r_t[31:0];
                w_mb = DRAW_MULT[31:0];
            end
            2'd1: begin
                w_ma = r_t[31:0];
                w_mb = DRAW_MULT[63:32];
            end
            default: begin
                w_ma = r_t[63:32];
                w_mb = DRAW_MULT[31:0];
            end
        endcase
    end

    assign w_mul = w_ma * w_mb;

    always_comb begin
        case (r_step)
            2'd1:    n_acc = r_prod;
            2'd2,
            2'd3:    n_acc = {r_acc[63:32] + r_prod[31:0], r_acc[31:0]};
            default: n_acc = r_acc;
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_fidx;
        w_wdata = r_base + {29'd0, r_off};
        case (r_state)
            S_MIX: begin
                w_we    = 1'b1;
                w_waddr = w_ptr_nx;
                w_wdata = w_t3;
            end
            S_FILL: begin
                w_we    = 1'b1;
            end
            default: begin
                w_we    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_words[w_waddr] <= w_wdata;
        end
        r_rd_s <= mem_words[r_ptr];
        r_rd_t <= mem_words[w_ptr_nx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_vs    <= 1'b0;
            r_vt    <= 1'b0;
        end else begin
            r_vs <= r_valid[r_ptr];
            r_vt <= r_valid[w_ptr_nx];
            if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
            end
        end
    end

    xs1024_divu u_divu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_acc[31:0]),
        .i_divisor  (r_span),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ptr         <= '0;
            r_first_seed  <= '0;
            r_active_seed <= '0;
            r_seeded      <= 1'b0;
            r_step        <= '0;
            r_fidx        <= '0;
            r_div_start   <= 1'b0;
            r_done        <= 1'b0;
            r_result      <= '0;
        end else begin
            r_done      <= 1'b0;
            r_div_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_ranged <= (i_req.req_type == REQ_RANGED);
                        r_lo     <= w_lo;
                        r_span   <= w_hi - w_lo + 32'd1;
                        r_fidx   <= '0;
                        r_off    <= '0;
                        r_result <= '0;
                        case (i_req.req_type)
                            REQ_DRAW,
                            REQ_RANGED: begin
                                r_state <= S_READ;
                            end
                            REQ_NEW_SEED: begin
                                if (i_req.seed_value == r_active_seed) begin
                                    r_done <= 1'b1;
                                end else begin
                                    r_base <= i_req.seed_value ^
                                              (i_req.seed_value >> SEED_SHR);
                                    r_active_seed <= i_req.seed_value;
                                    r_state       <= S_FILL;
                                end
                            end
                            REQ_RESET_SEED: begin
                                if (r_first_seed == r_active_seed) begin
                                    r_done <= 1'b1;
                                end else begin
                                    r_base <= r_first_seed ^ (r_first_seed >> SEED_SHR);
                                    r_active_seed <= r_first_seed;
                                    r_state       <= S_FILL;
                                end
                            end
                            REQ_INIT: begin
                                if (r_seeded) begin
                                    r_done <= 1'b1;
                                end else begin
                                    r_base <= i_req.seed_value ^
                                              (i_req.seed_value >> SEED_SHR);
                                    r_first_seed  <= i_req.seed_value;
                                    r_active_seed <= i_req.seed_value;
                                    r_seeded      <= 1'b1;
                                    r_state       <= S_FILL;
                                end
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_MIX;
                end
                S_MIX: begin
                    r_t     <= w_t3;
                    r_ptr   <= w_ptr_nx;
                    r_step  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= w_mul;
                    r_acc  <= n_acc;
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        if (r_ranged && (r_span != '0)) begin
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV;
                        end else begin
                            r_result.accepted     <= 1'b1;
                            r_result.raw_value    <= n_acc;
                            r_result.ranged_value <= r_ranged ? n_acc[31:0] : '0;
                            r_done                <= 1'b1;
                            r_state               <= S_IDLE;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_result.accepted     <= 1'b1;
                        r_result.raw_value    <= r_acc;
                        r_result.ranged_value <= w_div_rem + r_lo;
                        r_done                <= 1'b1;
                        r_state               <= S_IDLE;
                    end
                end
                S_FILL: begin
                    r_fidx <= r_fidx + 4'd1;
                    r_off  <= r_off + SEED_STEP;
                    if (r_fidx == 4'd15) begin
                        r_ptr             <= '0;
                        r_result.accepted <= 1'b1;
                        r_done            <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    `XS1024_ASSERT_NOW(a_refused_zero, o_done && !o_result.accepted, (o_result.raw_value == '0) && (o_result.ranged_value == '0), "refused word carries nonzero data")
    `XS1024_ASSERT_NEXT(a_accept_moves, i_start && !o_busy, o_busy || o_done, "accepted request neither started nor answered")
    `XS1024_ASSERT_NEXT(a_ptr_idle_hold, !o_busy, $stable(r_ptr), "word pointer moved while idle")
    `XS1024_ASSERT_NOW(a_div_only_ranged, r_div_start, r_ranged && (r_span != '0), "remainder unit started outside a ranged draw")

endmodule

`default_nettype wire

@@ hdl/xs1024_divu.sv @@
// Iterative 32-bit unsigned remainder unit, one quotient bit per cycle.
// Depends on nothing; used by xorshift1024_star_rng_core for ranged draws.
`default_nettype none

module xs1024_divu (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_rem
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_div;
    logic [32:0] w_shift;
    logic [32:0] w_diff;

    assign w_shift = {r_rem, r_quo[31]};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[30:0], 1'b0};
            if (!w_diff[32]) begin
                r_rem <= w_diff[31:0];
            end else begin
                r_rem <= w_shift[31:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

@@ test/xs1024_result_checker.sv @@
// Result checker for the xorshift1024* generator core: predicts each result word
// from the accepted requests and compares it with what the core returns.
// Depends on xs1024_pkg.

module xs1024_result_checker
    import xs1024_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  logic    i_done,
    input  t_req    i_req,
    input  t_result i_result,
    output int      o_mismatches,
    output int      o_outstanding,
    output int      o_checked
);

    logic [63:0] gen_words [16];
    logic [3:0]  gen_index;
    logic [63:0] initial_seed;
    logic [63:0] current_seed;
    logic        init_done;

    t_result     awaited_results [$];
    int          mismatch_total = 0;
    int          checked_total  = 0;

    task automatic fill_gen_words(input logic [63:0] seed);
        logic [63:0] base;
        base = seed ^ (seed >> SEED_SHR);
        for (int i = 0; i < 16; i++) begin
            gen_words[i] = base + 64'(i) * 64'(SEED_STEP);
        end
        gen_index = '0;
    endtask

    task automatic draw_product(output logic [63:0] product);
        logic [63:0] s;
        logic [63:0] t;
        logic [3:0]  p;
        s = gen_words[gen_index];
        p = gen_index + 4'd1;
        t = gen_words[p];
        t ^= t << MIX_SHL;
        t ^= t >> MIX_SHR;
        t ^= s ^ (s >> SEED_SHR);
        gen_words[p] = t;
        gen_index = p;
        product = t * DRAW_MULT;
    endtask

    task automatic predict_result(input t_req req, output t_result res);
        logic [63:0] product;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] span;
        logic [31:0] reduced;
        logic        reversed;
        res = '0;
        case (req.req_type)
            REQ_DRAW: begin
                draw_product(product);
                res.raw_value = product;
                res.accepted  = 1'b1;
            end
            REQ_RANGED: begin
                lo = req.range_low;
                hi = req.range_high;
                if (req.signed_bounds) begin
                    reversed = $signed(hi) < $signed(lo);
                end else begin
                    reversed = hi < lo;
                end
                if (reversed) begin
                    lo = req.range_high;
                    hi = req.range_low;
                end
                draw_product(product);
                reduced = product[31:0];
                span = hi - lo + 32'd1;
                if (span != 32'd0) begin
                    reduced = (reduced % span) + lo;
                end
                res.raw_value    = product;
                res.ranged_value = reduced;
                res.accepted     = 1'b1;
            end
            REQ_NEW_SEED: begin
                if (req.seed_value != current_seed) begin
                    fill_gen_words(req.seed_value);
                    current_seed = req.seed_value;
                    res.accepted = 1'b1;
                end
            end
            REQ_RESET_SEED: begin
                if (initial_seed != current_seed) begin
                    fill_gen_words(initial_seed);
                    current_seed = initial_seed;
                    res.accepted = 1'b1;
                end
            end
            REQ_INIT: begin
                if (!init_done) begin
                    fill_gen_words(req.seed_value);
                    initial_seed = req.seed_value;
                    current_seed = req.seed_value;
                    init_done    = 1'b1;
                    res.accepted = 1'b1;
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                gen_words[i] = '0;
            end
            gen_index    = '0;
            initial_seed = '0;
            current_seed = '0;
            init_done    = 1'b0;
            awaited_results.delete();
        end else begin
            if (i_done) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got %h",
                             $time, i_result);
                    mismatch_total++;
                end else begin
                    want = awaited_results.pop_front();
                    checked_total++;
                    if (i_result.accepted !== want.accepted) begin
                        $display("%0t: accepted mismatch, expected %0b, got %0b",
                                 $time, want.accepted, i_result.accepted);
                        mismatch_total++;
                    end
                    if (i_result.raw_value !== want.raw_value) begin
                        $display("%0t: raw_value mismatch, expected %h, got %h",
                                 $time, want.raw_value, i_result.raw_value);
                        mismatch_total++;
                    end
                    if (i_result.ranged_value !== want.ranged_value) begin
                        $display("%0t: ranged_value mismatch, expected %h, got %h",
                                 $time, want.ranged_value, i_result.ranged_value);
                        mismatch_total++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                predict_result(i_req, want);
                awaited_results.push_back(want);
            end
        end
        o_mismatches  <= mismatch_total;
        o_outstanding <= awaited_results.size();
        o_checked     <= checked_total;
    end

endmodule

@@ test/tb_xorshift1024_star_rng_core.sv @@
// Testbench top for the xorshift1024* generator core: drives directed and random
// requests with random idle gaps and gives the verdict.
// Depends on xs1024_pkg, xorshift1024_star_rng_core and xs1024_result_checker.

module tb_xorshift1024_star_rng_core;
    import xs1024_pkg::*;

    localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;
    localparam int         RANDOM_ITEMS     = 1150;
    localparam int         CALM_FIRST       = 500;
    localparam int         CALM_LAST        = 800;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_start = 1'b0;
    t_req    i_req   = '0;
    logic    o_busy;
    logic    o_done;
    t_result o_result;

    int          mismatches;
    int          outstanding;
    int          checked;
    int          n_draw    = 0;
    int          n_ranged  = 0;
    int          n_seeding = 0;
    int          n_unused  = 0;
    logic [63:0] last_seed = '0;

    xorshift1024_star_rng_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_req    (i_req),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    xs1024_result_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_busy        (o_busy),
        .i_done        (o_done),
        .i_req         (i_req),
        .i_result      (o_result),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_xorshift1024_star_rng_core: FAIL");
        $finish;
    end

    function automatic t_req make_req(input logic [2:0] code, input logic [63:0] seed,
                                      input logic [31:0] lo, input logic [31:0] hi,
                                      input logic sgn);
        t_req r;
        r.req_type      = code;
        r.seed_value    = seed;
        r.range_low     = lo;
        r.range_high    = hi;
        r.signed_bounds = sgn;
        return r;
    endfunction

    task automatic send_word(input t_req r);
        i_req   <= r;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        case (r.req_type)
            REQ_DRAW:   n_draw++;
            REQ_RANGED: n_ranged++;
            REQ_NEW_SEED, REQ_RESET_SEED, REQ_INIT: n_seeding++;
            default:    n_unused++;
        endcase
    endtask

    task automatic idle_for(input int cycles);
        i_start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_seed();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) return last_seed;
        if (roll < 20) return '0;
        if (roll < 25) return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic t_req pick_ranged();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] tmp;
        logic        sgn;
        int          mode;
        mode = $urandom_range(0, 9);
        sgn  = 1'($urandom_range(0, 1));
        case (mode)
            0: begin
                a = 32'h0000_0000;
                b = 32'hFFFF_FFFF;
            end
            1: begin
                a   = 32'h8000_0000;
                b   = 32'h7FFF_FFFF;
                sgn = 1'b1;
            end
            2: begin
                a = $urandom;
                b = a + 32'($urandom_range(0, 15));
            end
            3: begin
                a = $urandom;
                b = a;
            end
            4: begin
                a = $urandom_range(0, 1000) - 500;
                b = $urandom_range(0, 1000) - 500;
            end
            default: begin
                a = $urandom;
                b = $urandom;
            end
        endcase
        if ($urandom_range(0, 1)) begin
            tmp = a;
            a   = b;
            b   = tmp;
        end
        return make_req(REQ_RANGED, {$urandom, $urandom}, a, b, sgn);
    endfunction

    function automatic t_req pick_req();
        int          roll;
        logic [63:0] seed;
        roll = $urandom_range(0, 99);
        seed = pick_seed();
        if (roll < 30) return make_req(REQ_DRAW, {$urandom, $urandom}, $urandom, $urandom,
                                       1'($urandom_range(0, 1)));
        if (roll < 65) return pick_ranged();
        if (roll < 77) return make_req(REQ_NEW_SEED, seed, $urandom, $urandom, 1'b0);
        if (roll < 87) return make_req(REQ_RESET_SEED, seed, $urandom, $urandom, 1'b0);
        if (roll < 92) return make_req(REQ_INIT, seed, $urandom, $urandom, 1'b0);
        return make_req(3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST)),
                        {$urandom, $urandom}, $urandom, $urandom, 1'($urandom_range(0, 1)));
    endfunction

    initial begin : stimulus
        t_req r;
        int   done_items;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(make_req(REQ_DRAW, '0, '0, '0, 1'b0));
        send_word(make_req(REQ_RANGED, '0, 32'd5, 32'd9, 1'b0));
        send_word(make_req(REQ_RESET_SEED, '0, '0, '0, 1'b0));
        send_word(make_req(REQ_NEW_SEED, '0, '0, '0, 1'b0));
        send_word(make_req(REQ_UNUSED_FIRST, '1, '1, '1, 1'b1));
        send_word(make_req(REQ_UNUSED_LAST, '0, '0, '0, 1'b0));
        send_word(make_req(REQ_NEW_SEED, 64'h0123_4567_89AB_CDEF, '0, '0, 1'b0));
        send_word(make_req(REQ_RESET_SEED, '0, '0, '0, 1'b0));
        send_word(make_req(REQ_INIT, '1, '0, '0, 1'b0));
        send_word(make_req(REQ_INIT, '0, '0, '0, 1'b0));
        send_word(make_req(REQ_DRAW, '0, '0, '0, 1'b0));
        send_word(make_req(REQ_RANGED, '0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0));
        send_word(make_req(REQ_RANGED, '0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
        send_word(make_req(REQ_RANGED, '0, 32'd1000, 32'd10, 1'b0));
        send_word(make_req(REQ_RANGED, '0, 32'hFFFF_FFF0, 32'h0000_0010, 1'b1));
        send_word(make_req(REQ_RANGED, '0, 32'hFFFF_FFF0, 32'h0000_0010, 1'b0));
        send_word(make_req(REQ_RANGED, '0, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 1'b0));
        send_word(make_req(REQ_RANGED, '0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1));
        send_word(make_req(REQ_NEW_SEED, '1, '0, '0, 1'b0));
        send_word(make_req(REQ_NEW_SEED, '0, '0, '0, 1'b0));
        send_word(make_req(REQ_RESET_SEED, '0, '0, '0, 1'b0));
        send_word(make_req(REQ_RESET_SEED, '0, '0, '0, 1'b0));
        send_word(make_req(REQ_DRAW, '0, '0, '0, 1'b0));

        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            r = pick_req();
            if ((done_items < CALM_FIRST || done_items >= CALM_LAST)
                    && $urandom_range(0, 99) < 10) begin
                idle_for($urandom_range(1, 45));
            end
            send_word(r);
            if (r.req_type == REQ_NEW_SEED || r.req_type == REQ_INIT) begin
                last_seed = r.seed_value;
            end
            done_items++;
        end

        i_start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("Sent %0d draws, %0d ranged draws, %0d seeding requests, %0d unused codes.",
                 n_draw, n_ranged, n_seeding, n_unused);
        $display("Compared %0d result words, %0d still awaited, %0d mismatches.",
                 checked, outstanding, mismatches);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_xorshift1024_star_rng_core: PASS");
        end else begin
            $display("tb_xorshift1024_star_rng_core: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/xs1024_pkg.sv
hdl/xs1024_divu.sv
hdl/xorshift1024_star_rng_core.sv
test/xs1024_result_checker.sv
test/tb_xorshift1024_star_rng_core.sv
